@@ sv/acmac_pkg.sv @@
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared types, constants and AES helper functions for the CMAC tag engine.
// ----------------------------------------------------------------------------
package acmac_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam logic [7:0] CMAC_RB  = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [1:0] CFG_KEY_HI     = 2'd0;
    localparam logic [1:0] CFG_KEY_LO     = 2'd1;
    localparam logic [1:0] CFG_TAG_LENGTH = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // one queued item between the front and the back
    typedef struct packed {
        logic         is_end;
        logic         is_full;
        logic [127:0] block;
        logic [127:0] expected;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits in bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        return v[127 - 8*i -: 8];
    endfunction

    // one AES round; final drops MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last_round);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                t[w + 4*c] = SBOX[get_byte(s, w + 4*((c + w) % 4))];
            end
        end
        if (!last_round) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                x = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

    // next round key from the current one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        g = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CMAC_RB : 8'h00)};
    endfunction

endpackage

@@ sv/acmac_front.sv @@
// ----------------------------------------------------------------------------
// acmac_front
// Collects message bytes into blocks and hands full or final blocks to the queue.
// ----------------------------------------------------------------------------
module acmac_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [7:0]           s_byte,
    input  logic [127:0]         s_expected,
    output logic                 q_valid,
    input  logic                 q_ready,
    output acmac_pkg::job_t      q_job
);

    logic [127:0] buf_reg;
    logic [4:0]   count_reg;
    logic         take;
    logic [127:0] padded;

    // a full buffer is pushed only when a further byte or the end marker arrives
    assign s_ready = q_ready || !(s_kind == acmac_pkg::KIND_END || count_reg[4]);
    assign take    = s_valid && s_ready;
    assign q_valid = s_valid && (s_kind == acmac_pkg::KIND_END || count_reg[4]);

    always_comb begin
        padded = buf_reg;
        for (int i = 0; i < acmac_pkg::BLOCK_BYTES; i++) begin
            if (5'(i) == count_reg) begin
                padded[127 - 8*i -: 8] = acmac_pkg::PAD_BYTE;
            end else if (5'(i) > count_reg) begin
                padded[127 - 8*i -: 8] = 8'h00;
            end
        end
        q_job.is_end   = s_kind;
        q_job.is_full  = count_reg[4];
        q_job.block    = count_reg[4] ? buf_reg : padded;
        q_job.expected = s_expected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (take) begin
            if (s_kind == acmac_pkg::KIND_END) begin
                count_reg <= '0;
            end else if (count_reg[4]) begin
                count_reg <= 5'd1;
            end else begin
                count_reg <= count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_kind == acmac_pkg::KIND_DATA) begin
            buf_reg[127 - 8*(count_reg[4] ? 0 : int'(count_reg[3:0])) -: 8] <= s_byte;
        end
    end

endmodule

@@ sv/acmac_queue.sv @@
// ----------------------------------------------------------------------------
// acmac_queue
// Two-entry queue between block collection and the cipher core.
// ----------------------------------------------------------------------------
module acmac_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  acmac_pkg::job_t  in_job,
    output logic             out_valid,
    input  logic             out_ready,
    output acmac_pkg::job_t  out_job
);

    acmac_pkg::job_t mem_reg [2];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_job;
    end

endmodule

@@ sv/acmac_back.sv @@
// ----------------------------------------------------------------------------
// acmac_back
// Iterative AES-128 core: derives subkeys, chains blocks, finishes the tag.
// ----------------------------------------------------------------------------
module acmac_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [127:0]     key,
    input  logic             key_wr,
    input  logic [4:0]       tag_length,
    input  logic             j_valid,
    output logic             j_ready,
    input  acmac_pkg::job_t  j_job,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [127:0]     m_tag,
    output logic             m_match
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

    state_t       state_reg;
    logic         ready_keys_reg;
    logic         deriving_reg;
    logic         is_end_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rc_reg;
    logic [127:0] st_reg, rk_reg, chain_reg, k1_reg, k2_reg, exp_reg;
    logic         m_valid_reg;
    logic [127:0] tag_reg;
    logic         match_reg;

    logic [127:0] rk_next, st_next, l_dbl, mask, tagv;
    logic [4:0]   len;

    assign rk_next = acmac_pkg::key_step(rk_reg, rc_reg);
    assign st_next = acmac_pkg::aes_round(st_reg, rk_next, round_reg == 4'd10);
    assign l_dbl   = acmac_pkg::gf_double(st_next);
    assign j_ready = state_reg == S_IDLE && ready_keys_reg && !key_wr &&
                     (!j_job.is_end || !m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_tag   = tag_reg;
    assign m_match = match_reg;

    always_comb begin
        len = (tag_length == 5'd0) ? 5'd1 : (tag_length > 5'd16 ? 5'd16 : tag_length);
        for (int i = 0; i < 16; i++) begin
            mask[127 - 8*i -: 8] = (5'(i) < len) ? 8'hff : 8'h00;
        end
        tagv = st_next & mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ready_keys_reg <= 1'b0;
            deriving_reg   <= 1'b0;
            chain_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (key_wr) begin
                        ready_keys_reg <= 1'b0;
                    end else if (!ready_keys_reg) begin
                        st_reg       <= key;
                        rk_reg       <= key;
                        rc_reg       <= 8'h01;
                        round_reg    <= 4'd1;
                        deriving_reg <= 1'b1;
                        state_reg    <= S_RUN;
                    end else if (j_valid && j_ready) begin
                        st_reg       <= chain_reg ^ j_job.block ^ key ^
                                        (j_job.is_end ? (j_job.is_full ? k1_reg : k2_reg)
                                                      : '0);
                        rk_reg       <= key;
                        rc_reg       <= 8'h01;
                        round_reg    <= 4'd1;
                        is_end_reg   <= j_job.is_end;
                        exp_reg      <= j_job.expected;
                        deriving_reg <= 1'b0;
                        state_reg    <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (deriving_reg && key_wr) begin
                        state_reg <= S_IDLE;
                    end else begin
                        st_reg    <= st_next;
                        rk_reg    <= rk_next;
                        rc_reg    <= acmac_pkg::xt(rc_reg);
                        round_reg <= round_reg + 4'd1;
                        if (round_reg == 4'd10) begin
                            state_reg <= S_IDLE;
                            if (deriving_reg) begin
                                k1_reg         <= l_dbl;
                                k2_reg         <= acmac_pkg::gf_double(l_dbl);
                                ready_keys_reg <= 1'b1;
                            end else if (is_end_reg) begin
                                chain_reg   <= '0;
                                tag_reg     <= tagv;
                                match_reg   <= tagv == (exp_reg & mask);
                                m_valid_reg <= 1'b1;
                            end else begin
                                chain_reg <= st_next;
                            end
                        end
                    end
                    if (!deriving_reg && key_wr) ready_keys_reg <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/aes_cmac_tag_engine.sv @@
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine
// AES-128 CMAC over a byte stream with tag truncation and verify flag.
// Bytes enter the buffer one per cycle while s_tready is high; each block then runs
// through the iterative AES round unit, so sustained rate is one byte per cycle unless stalled.
// Subkeys are derived after reset or a key write.
// The tag is registered once the end-of-message block has passed the queue and the AES
// rounds; a block in progress or a held tag delays it.
// Reset: synchronous active-low aresetn clears control and key, sets tag length 16.
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // data_byte[7:0], expected_hi[71:8], expected_lo[135:72]
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // tag_hi[63:0], tag_lo[127:64], match[128], zero pad
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic [63:0]     key_hi_reg, key_lo_reg;
    logic [4:0]      tag_length_reg;
    logic            key_wr;
    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    acmac_pkg::job_t fq_job, qb_job;
    logic [127:0]    tag;
    logic            match;

    assign key_wr = cfg_we && (cfg_index == acmac_pkg::CFG_KEY_HI ||
                               cfg_index == acmac_pkg::CFG_KEY_LO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg     <= '0;
            key_lo_reg     <= '0;
            tag_length_reg <= 5'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                acmac_pkg::CFG_KEY_HI:     key_hi_reg     <= cfg_data;
                acmac_pkg::CFG_KEY_LO:     key_lo_reg     <= cfg_data;
                acmac_pkg::CFG_TAG_LENGTH: tag_length_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    acmac_front u_front (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready), .s_kind(s_tuser),
        .s_byte(s_tdata[7:0]), .s_expected({s_tdata[71:8], s_tdata[135:72]}),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_job(fq_job)
    );

    acmac_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    acmac_back u_back (
        .aclk, .aresetn,
        .key({key_hi_reg, key_lo_reg}), .key_wr, .tag_length(tag_length_reg),
        .j_valid(qb_valid), .j_ready(qb_ready), .j_job(qb_job),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_tag(tag), .m_match(match)
    );

    assign m_tdata = {7'd0, match, tag[63:0], tag[127:64]};

`ifndef SYNTHESIS
    a_tag_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && tag_length_reg == 5'd1 |-> m_tdata[119:64] == '0)
        else $error("tag bytes beyond length not zero");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");
`endif

endmodule
